// ===== sv/geodetic_to_ecef_unit_macros.svh =====
// Assertion macros used by the checker file of the geodetic to ECEF unit.
`ifndef GEODETIC_TO_ECEF_UNIT_MACROS_SVH
`define GEODETIC_TO_ECEF_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define G2E_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define G2E_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/g2e_pkg.sv =====
// Shared types, constants and arithmetic helpers of the geodetic to ECEF unit.
package g2e_pkg;

  localparam int unsigned MAX_STAGES = 48;
  localparam int unsigned ROOT_STEPS = 41;
  localparam int unsigned DIV_STEPS  = 60;
  localparam int unsigned RECIP_LAT  = ROOT_STEPS + DIV_STEPS;

  localparam logic CFG_AXIS = 1'b0;
  localparam logic CFG_ECC  = 1'b1;

  typedef logic [72:0]        prod_t;
  typedef logic [62:0]        mag_t;
  typedef logic signed [32:0] trig_t;

  localparam mag_t MAG_CAP = mag_t'(1) << 62;

  typedef struct packed {
    logic signed [40:0] h16;
    trig_t              sb;
    trig_t              cb;
    trig_t              sl;
    trig_t              cl;
    logic               degen;
  } side_t;

  function automatic logic [31:0] atan_val(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051D;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2E;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517C;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A2F;
      19: v = 32'h00000517;
      20: v = 32'h0000028B;
      21: v = 32'h00000145;
      22: v = 32'h000000A2;
      23: v = 32'h00000051;
      24: v = 32'h00000028;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000002;
      29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Joins the two partial products of a split multiply, rounds half up at
  // the given shift and caps the magnitude.
  function automatic mag_t mul_round(input prod_t ph, input prod_t pl, input int unsigned sh);
    logic [105:0] full;
    logic [105:0] q;
    full = ({33'd0, ph} << 32) + {33'd0, pl} + (106'd1 << (sh - 1));
    q = full >> sh;
    if (q > {43'd0, MAG_CAP}) return MAG_CAP;
    return q[62:0];
  endfunction

  function automatic logic signed [63:0] apply_sign(input mag_t m, input logic neg);
    logic signed [63:0] v;
    v = $signed({1'b0, m});
    return neg ? -v : v;
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [40:0] trig_mag(input trig_t v);
    logic [32:0] m;
    m = v[32] ? 33'(-v) : 33'(v);
    return {8'd0, m};
  endfunction

  function automatic logic signed [40:0] sat41(input logic signed [63:0] v);
    if (v > 64'sd1099511627775) return 41'sh0FFFFFFFFFF;
    if (v < -64'sd1099511627776) return 41'sh10000000000;
    return v[40:0];
  endfunction

endpackage

// ===== sv/g2e_cordic.sv =====
// Unrolled rotation-mode CORDIC giving Q30 sine and cosine of a binary angle.
module g2e_cordic #(
  parameter int unsigned STAGES = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [31:0]     angle_i,
  output logic            valid_o,
  output g2e_pkg::trig_t  sin_o,
  output g2e_pkg::trig_t  cos_o
);

  localparam int unsigned NS = (STAGES > g2e_pkg::MAX_STAGES) ? g2e_pkg::MAX_STAGES : STAGES;
  localparam logic signed [43:0] GAIN = 44'sd667681663044;

  logic signed [43:0] x_q [NS+1];
  logic signed [43:0] y_q [NS+1];
  logic signed [33:0] z_q [NS+1];
  logic               flip_q [NS+1];
  logic               vld_q [NS+1];

  logic signed [31:0] ang_s;
  logic               need_flip;
  logic [31:0]        ang_turned;

  assign ang_s      = $signed(angle_i);
  assign need_flip  = (ang_s > 32'sd1073741824) || (ang_s < -32'sd1073741824);
  assign ang_turned = angle_i + 32'h80000000;

  // Angles beyond a quarter turn are rotated by half a turn; the results
  // are negated at the end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= GAIN;
    y_q[0]    <= '0;
    z_q[0]    <= need_flip ? 34'($signed(ang_turned)) : 34'(ang_s);
    flip_q[0] <= need_flip;
  end

  for (genvar g = 0; g < NS; g++) begin : g_stage
    localparam logic signed [33:0] ATAN = $signed({2'b00, g2e_pkg::atan_val(g)});
    logic signed [43:0] dx;
    logic signed [43:0] dy;
    assign dx = y_q[g] >>> g;
    assign dy = x_q[g] >>> g;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      flip_q[g+1] <= flip_q[g];
      if (z_q[g] >= 0) begin
        x_q[g+1] <= x_q[g] - dx;
        y_q[g+1] <= y_q[g] + dy;
        z_q[g+1] <= z_q[g] - ATAN;
      end else begin
        x_q[g+1] <= x_q[g] + dx;
        y_q[g+1] <= y_q[g] - dy;
        z_q[g+1] <= z_q[g] + ATAN;
      end
    end
  end

  logic signed [43:0] xr;
  logic signed [43:0] yr;
  logic               vld_out_q;
  g2e_pkg::trig_t     sin_q;
  g2e_pkg::trig_t     cos_q;

  assign xr = (x_q[NS] + 44'sd512) >>> 10;
  assign yr = (y_q[NS] + 44'sd512) >>> 10;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q <= flip_q[NS] ? -$signed(xr[32:0]) : $signed(xr[32:0]);
    sin_q <= flip_q[NS] ? -$signed(yr[32:0]) : $signed(yr[32:0]);
  end

  assign valid_o = vld_out_q;
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

endmodule

// ===== sv/g2e_recip.sv =====
// Pipelined square root and restoring divide giving the prime-vertical radius.
module g2e_recip (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [40:0] w2_i,
  input  logic [35:0] axis_i,
  output logic        valid_o,
  output logic [59:0] n_o
);

  localparam int unsigned RS = g2e_pkg::ROOT_STEPS;
  localparam int unsigned DS = g2e_pkg::DIV_STEPS;

  // Root: one result bit per stage, remainder kept as w2 * 2^40 - r^2.
  logic [81:0] rm_q [RS];
  logic [40:0] rt_q [RS];
  logic        rv_q [RS];

  for (genvar j = 0; j < RS; j++) begin : g_root
    localparam int unsigned B = RS - 1 - j;
    logic [81:0] rem_in;
    logic [40:0] r_in;
    logic        v_in;
    logic [81:0] trial;
    logic        fits;

    if (j == 0) begin : g_first
      assign rem_in = {1'b0, w2_i, 40'd0};
      assign r_in   = '0;
      assign v_in   = valid_i;
    end else begin : g_next
      assign rem_in = rm_q[j-1];
      assign r_in   = rt_q[j-1];
      assign v_in   = rv_q[j-1];
    end

    assign trial = ({41'd0, r_in} << (B + 1)) + (82'd1 << (2 * B));
    assign fits  = rem_in >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[j] <= 1'b0;
      end else begin
        rv_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rm_q[j] <= fits ? rem_in - trial : rem_in;
      rt_q[j] <= fits ? (r_in | (41'd1 << B)) : r_in;
    end
  end

  // Divide: w2 > 0 keeps the divisor >= 2^20; the top twenty dividend
  // bits form the starting remainder and sixty quotient bits remain.
  logic [41:0] dm_q [DS];
  logic [40:0] dd_q [DS];
  logic [59:0] dq_q [DS];
  logic        dv_q [DS];

  for (genvar j = 0; j < DS; j++) begin : g_div
    localparam int unsigned K = DS - 1 - j;
    logic [41:0] rem_in;
    logic [40:0] d_in;
    logic [59:0] q_in;
    logic        v_in;
    logic        dbit;
    logic [41:0] shifted;
    logic        fits;

    if (j == 0) begin : g_first
      assign rem_in = {22'd0, axis_i[35:16]};
      assign d_in   = rt_q[RS-1];
      assign q_in   = '0;
      assign v_in   = rv_q[RS-1];
    end else begin : g_next
      assign rem_in = dm_q[j-1];
      assign d_in   = dd_q[j-1];
      assign q_in   = dq_q[j-1];
      assign v_in   = dv_q[j-1];
    end

    if (K >= 44) begin : g_abit
      assign dbit = axis_i[K-44];
    end else begin : g_zbit
      assign dbit = 1'b0;
    end

    assign shifted = {rem_in[40:0], dbit};
    assign fits    = shifted >= {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else begin
        dv_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dm_q[j] <= fits ? shifted - {1'b0, d_in} : shifted;
      dd_q[j] <= d_in;
      dq_q[j] <= {q_in[58:0], fits};
    end
  end

  assign valid_o = dv_q[DS-1];
  assign n_o     = dq_q[DS-1];

endmodule

// ===== sv/geodetic_to_ecef_unit.sv =====
// Top level of the geodetic to ECEF conversion pipeline.
//
//   channel   ports                                         handshake
//   request   start_i, latitude_i, longitude_i, height_i    start_i && !busy_o
//   result    done_o, ecef_x_o, ecef_y_o, ecef_z_o, status_o   done_o, one cycle
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i              cfg_we_i
//
// A request is taken every cycle; busy_o stays low. Each result passes the
// CORDIC, sin^2 and e2, the root, the divide and the coordinate multiplies
// in that order. Reset clears the valid bits and loads the default
// ellipsoid. The receiver cannot stall, so nothing ever waits.
module geodetic_to_ecef_unit #(
  parameter int unsigned CORDIC_STAGES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] latitude_i,
  input  logic signed [31:0] longitude_i,
  input  logic signed [36:0] height_i,
  output logic               done_o,
  output logic signed [40:0] ecef_x_o,
  output logic signed [40:0] ecef_y_o,
  output logic signed [40:0] ecef_z_o,
  output logic               status_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [39:0]        cfg_wdata_i
);

  localparam int unsigned NS = (CORDIC_STAGES > g2e_pkg::MAX_STAGES) ?
                               g2e_pkg::MAX_STAGES : CORDIC_STAGES;
  localparam int unsigned CL = NS + 2;
  localparam int unsigned RL = g2e_pkg::RECIP_LAT;

  logic [35:0] axis_q;
  logic [39:0] ecc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= 36'd6531212288;
      ecc_q  <= 40'd7360548639;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        g2e_pkg::CFG_AXIS: axis_q <= cfg_wdata_i[35:0];
        g2e_pkg::CFG_ECC:  ecc_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // CORDIC lanes
  logic           lat_v;
  logic           lon_v;
  g2e_pkg::trig_t sb;
  g2e_pkg::trig_t cb;
  g2e_pkg::trig_t sl;
  g2e_pkg::trig_t cl;

  g2e_cordic #(.STAGES(CORDIC_STAGES)) u_lat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .angle_i (latitude_i),
    .valid_o (lat_v),
    .sin_o   (sb),
    .cos_o   (cb)
  );

  g2e_cordic #(.STAGES(CORDIC_STAGES)) u_lon (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .angle_i (longitude_i),
    .valid_o (lon_v),
    .sin_o   (sl),
    .cos_o   (cl)
  );

  logic signed [36:0] hd_q [CL];

  always_ff @(posedge clk_i) begin
    hd_q[0] <= height_i;
    for (int i = 1; i < CL; i++) begin
      hd_q[i] <= hd_q[i-1];
    end
  end

  // Stage 1: sin^2 of latitude.
  logic            s1_v_q;
  g2e_pkg::side_t  s1_side_q;
  logic [63:0]     s1_s2_q;
  logic [40:0]     ub;

  assign ub = g2e_pkg::trig_mag(sb);

  always_ff @(posedge clk_i) begin
    s1_side_q.h16   <= $signed({hd_q[CL-1], 4'd0});
    s1_side_q.sb    <= sb;
    s1_side_q.cb    <= cb;
    s1_side_q.sl    <= sl;
    s1_side_q.cl    <= cl;
    s1_side_q.degen <= 1'b0;
    s1_s2_q         <= 64'(ub[31:0]) * 64'(ub[31:0]);
  end

  // Stage 2: partial products of e2 * sin^2.
  logic            s2_v_q;
  g2e_pkg::side_t  s2_side_q;
  g2e_pkg::prod_t  s2_ph_q;
  g2e_pkg::prod_t  s2_pl_q;

  always_ff @(posedge clk_i) begin
    s2_side_q <= s1_side_q;
    s2_ph_q   <= g2e_pkg::prod_t'(s1_s2_q[63:32]) * g2e_pkg::prod_t'(ecc_q);
    s2_pl_q   <= g2e_pkg::prod_t'(s1_s2_q[31:0]) * g2e_pkg::prod_t'(ecc_q);
  end

  // Stage 3: w2 = 1 - e2 sin^2 and the degenerate test.
  logic               s3_v_q;
  g2e_pkg::side_t     s3_side_q;
  logic [40:0]        s3_w2_q;
  g2e_pkg::mag_t      t_c;
  logic signed [63:0] w2_c;
  logic               degen_c;

  assign t_c     = g2e_pkg::mul_round(s2_ph_q, s2_pl_q, 60);
  assign w2_c    = 64'sd1099511627776 - $signed({1'b0, t_c});
  assign degen_c = w2_c <= 64'sd1;

  // The degenerate flag is the lowest bit of the side record.
  always_ff @(posedge clk_i) begin
    s3_side_q <= {s2_side_q[$bits(g2e_pkg::side_t)-1:1], degen_c};
    s3_w2_q   <= degen_c ? '0 : w2_c[40:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= lat_v && lon_v;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // Root and divide, with the side data delayed alongside.
  logic           rc_v;
  logic [59:0]    rc_n;
  g2e_pkg::side_t sd_q [RL];

  g2e_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_v_q),
    .w2_i    (s3_w2_q),
    .axis_i  (axis_q),
    .valid_o (rc_v),
    .n_o     (rc_n)
  );

  always_ff @(posedge clk_i) begin
    sd_q[0] <= s3_side_q;
    for (int i = 1; i < RL; i++) begin
      sd_q[i] <= sd_q[i-1];
    end
  end

  // Stage M1: partial products of N(1-e2) and (N+h) cos lat.
  logic               m1_v_q;
  g2e_pkg::side_t     m1_side_q;
  g2e_pkg::prod_t     m1_nz_ph_q;
  g2e_pkg::prod_t     m1_nz_pl_q;
  g2e_pkg::prod_t     m1_p1_ph_q;
  g2e_pkg::prod_t     m1_p1_pl_q;
  logic               m1_p1_neg_q;
  logic [63:0]        n_ext;
  logic signed [63:0] nh_c;
  logic [63:0]        nh_mag;
  logic [40:0]        cb_mag;
  logic [40:0]        ome;

  assign n_ext  = {4'd0, rc_n};
  assign nh_c   = $signed(n_ext) + 64'($signed(sd_q[RL-1].h16));
  assign nh_mag = g2e_pkg::abs64(nh_c);
  assign cb_mag = g2e_pkg::trig_mag(sd_q[RL-1].cb);
  assign ome    = {1'b1, 40'd0} - {1'b0, ecc_q};

  always_ff @(posedge clk_i) begin
    m1_side_q   <= sd_q[RL-1];
    m1_nz_ph_q  <= g2e_pkg::prod_t'(n_ext[63:32]) * g2e_pkg::prod_t'(ome);
    m1_nz_pl_q  <= g2e_pkg::prod_t'(n_ext[31:0]) * g2e_pkg::prod_t'(ome);
    m1_p1_ph_q  <= g2e_pkg::prod_t'(nh_mag[63:32]) * g2e_pkg::prod_t'(cb_mag);
    m1_p1_pl_q  <= g2e_pkg::prod_t'(nh_mag[31:0]) * g2e_pkg::prod_t'(cb_mag);
    m1_p1_neg_q <= nh_c[63] ^ sd_q[RL-1].cb[32];
  end

  // Stage M2: round Nz and p1.
  logic           m2_v_q;
  g2e_pkg::side_t m2_side_q;
  g2e_pkg::mag_t  m2_nz_q;
  g2e_pkg::mag_t  m2_p1_q;
  logic           m2_p1_neg_q;

  always_ff @(posedge clk_i) begin
    m2_side_q   <= m1_side_q;
    m2_nz_q     <= g2e_pkg::mul_round(m1_nz_ph_q, m1_nz_pl_q, 40);
    m2_p1_q     <= g2e_pkg::mul_round(m1_p1_ph_q, m1_p1_pl_q, 30);
    m2_p1_neg_q <= m1_p1_neg_q;
  end

  // Stage M3: partial products of the three coordinates.
  logic               m3_v_q;
  logic               m3_degen_q;
  g2e_pkg::prod_t     m3_x_ph_q;
  g2e_pkg::prod_t     m3_x_pl_q;
  g2e_pkg::prod_t     m3_y_ph_q;
  g2e_pkg::prod_t     m3_y_pl_q;
  g2e_pkg::prod_t     m3_z_ph_q;
  g2e_pkg::prod_t     m3_z_pl_q;
  logic               m3_x_neg_q;
  logic               m3_y_neg_q;
  logic               m3_z_neg_q;
  logic [63:0]        p1_ext;
  logic signed [63:0] p3_c;
  logic [63:0]        p3_mag;
  logic [40:0]        cl_mag;
  logic [40:0]        sl_mag;
  logic [40:0]        sb_mag;

  assign p1_ext = {1'b0, m2_p1_q};
  assign p3_c   = $signed({1'b0, m2_nz_q}) + 64'($signed(m2_side_q.h16));
  assign p3_mag = g2e_pkg::abs64(p3_c);
  assign cl_mag = g2e_pkg::trig_mag(m2_side_q.cl);
  assign sl_mag = g2e_pkg::trig_mag(m2_side_q.sl);
  assign sb_mag = g2e_pkg::trig_mag(m2_side_q.sb);

  always_ff @(posedge clk_i) begin
    m3_degen_q <= m2_side_q.degen;
    m3_x_ph_q  <= g2e_pkg::prod_t'(p1_ext[63:32]) * g2e_pkg::prod_t'(cl_mag);
    m3_x_pl_q  <= g2e_pkg::prod_t'(p1_ext[31:0]) * g2e_pkg::prod_t'(cl_mag);
    m3_y_ph_q  <= g2e_pkg::prod_t'(p1_ext[63:32]) * g2e_pkg::prod_t'(sl_mag);
    m3_y_pl_q  <= g2e_pkg::prod_t'(p1_ext[31:0]) * g2e_pkg::prod_t'(sl_mag);
    m3_z_ph_q  <= g2e_pkg::prod_t'(p3_mag[63:32]) * g2e_pkg::prod_t'(sb_mag);
    m3_z_pl_q  <= g2e_pkg::prod_t'(p3_mag[31:0]) * g2e_pkg::prod_t'(sb_mag);
    m3_x_neg_q <= m2_p1_neg_q ^ m2_side_q.cl[32];
    m3_y_neg_q <= m2_p1_neg_q ^ m2_side_q.sl[32];
    m3_z_neg_q <= p3_c[63] ^ m2_side_q.sb[32];
  end

  // Stage M4: round, sign and saturate into the output registers.
  logic               done_q;
  logic               status_q;
  logic signed [40:0] x_q;
  logic signed [40:0] y_q;
  logic signed [40:0] z_q;
  logic signed [63:0] xv;
  logic signed [63:0] yv;
  logic signed [63:0] zv;

  assign xv = g2e_pkg::apply_sign(g2e_pkg::mul_round(m3_x_ph_q, m3_x_pl_q, 34), m3_x_neg_q);
  assign yv = g2e_pkg::apply_sign(g2e_pkg::mul_round(m3_y_ph_q, m3_y_pl_q, 34), m3_y_neg_q);
  assign zv = g2e_pkg::apply_sign(g2e_pkg::mul_round(m3_z_ph_q, m3_z_pl_q, 34), m3_z_neg_q);

  always_ff @(posedge clk_i) begin
    x_q <= m3_degen_q ? '0 : g2e_pkg::sat41(xv);
    y_q <= m3_degen_q ? '0 : g2e_pkg::sat41(yv);
    z_q <= m3_degen_q ? '0 : g2e_pkg::sat41(zv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q   <= 1'b0;
      m2_v_q   <= 1'b0;
      m3_v_q   <= 1'b0;
      done_q   <= 1'b0;
      status_q <= 1'b0;
    end else begin
      m1_v_q   <= rc_v;
      m2_v_q   <= m1_v_q;
      m3_v_q   <= m2_v_q;
      done_q   <= m3_v_q;
      status_q <= m3_degen_q;
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign ecef_x_o = x_q;
  assign ecef_y_o = y_q;
  assign ecef_z_o = z_q;

endmodule

// ===== sv/g2e_checker.sv =====
// Port-level checker of the geodetic to ECEF unit and its bind statement.
`include "geodetic_to_ecef_unit_macros.svh"

module g2e_checker #(
  parameter int unsigned CORDIC_STAGES = 32
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic signed [31:0] latitude_i,
  input logic               done_o,
  input logic signed [40:0] ecef_x_o,
  input logic signed [40:0] ecef_y_o,
  input logic signed [40:0] ecef_z_o,
  input logic               status_o
);

  localparam int unsigned NS  = (CORDIC_STAGES > g2e_pkg::MAX_STAGES) ?
                                g2e_pkg::MAX_STAGES : CORDIC_STAGES;
  localparam int unsigned LAT = NS + 2 + 3 + g2e_pkg::RECIP_LAT + 4;

  logic acc;
  logic acc_eq;
  logic degen_out;
  logic all_zero;

  assign acc       = start_i && !busy_o && rst_ni;
  assign acc_eq    = acc && (latitude_i == 32'sd0);
  assign degen_out = done_o && status_o;
  assign all_zero  = (ecef_x_o == 41'sd0) && (ecef_y_o == 41'sd0) && (ecef_z_o == 41'sd0);

  // A degenerate result carries zero coordinates.
  `G2E_ASSERT_IMP(a_degen_zero, clk_i, rst_ni, degen_out, all_zero, "degenerate not zero")

  // Every result belongs to a request taken a fixed latency earlier.
  `G2E_ASSERT_IMP(a_latency, clk_i, rst_ni, done_o, $past(acc, LAT), "result without request")

  // A point on the equator never yields a degenerate radius.
  `G2E_ASSERT_IMP(a_equator, clk_i, rst_ni, $past(acc_eq, LAT), !status_o, "equator degenerate")

endmodule

bind geodetic_to_ecef_unit g2e_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_g2e_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .latitude_i (latitude_i),
  .done_o     (done_o),
  .ecef_x_o   (ecef_x_o),
  .ecef_y_o   (ecef_y_o),
  .ecef_z_o   (ecef_z_o),
  .status_o   (status_o)
);

// ===== bench/tb_geodetic_to_ecef_unit.sv =====
// Self-checking testbench of the geodetic to ECEF conversion unit.
`timescale 1ns / 100ps

module tb_geodetic_to_ecef_unit;

  localparam int unsigned NUM_STAGES = 32;
  localparam int unsigned RUN_STAGES = (NUM_STAGES > 48) ? 48 : NUM_STAGES;
  localparam int unsigned LATENCY    = RUN_STAGES + 110;
  localparam longint      CYCLE_LIMIT = 400000;
  localparam longint      CORDIC_GAIN = 64'sd667681663044;
  localparam logic [63:0] CAP62 = 64'd1 << 62;
  localparam logic [63:0] Q40_ONE = 64'd1 << 40;
  localparam logic [35:0] AXIS_DEFAULT = 36'd6531212288;
  localparam logic [39:0] ECC_DEFAULT = 40'd7360548639;
  localparam logic [31:0] ARCTAN [0:29] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  typedef struct packed {
    logic signed [31:0] lat;
    logic signed [31:0] lon;
    logic signed [36:0] hgt;
  } point_t;

  typedef struct packed {
    logic signed [40:0] x;
    logic signed [40:0] y;
    logic signed [40:0] z;
    logic               degen;
  } coord_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic signed [31:0] latitude_i;
  logic signed [31:0] longitude_i;
  logic signed [36:0] height_i;
  logic               done_o;
  logic signed [40:0] ecef_x_o;
  logic signed [40:0] ecef_y_o;
  logic signed [40:0] ecef_z_o;
  logic               status_o;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [39:0]        cfg_wdata_i;

  point_t      point_q[$];
  coord_t      coord_q[$];
  logic [35:0] axis_r;
  logic [39:0] ecc_r;
  int          err_cnt;
  longint      cyc_cnt;
  int          burst_left;
  int          gap_left;

  geodetic_to_ecef_unit #(.CORDIC_STAGES(NUM_STAGES)) dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Rounded product a*b / 2^sh with the magnitude capped at 2^62.
  function automatic logic [63:0] mul_rnd(input logic [63:0] a, input logic [63:0] b,
                                          input int sh);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b} + (128'd1 << (sh - 1))) >> sh;
    if (p > {64'd0, CAP62}) return CAP62;
    return p[63:0];
  endfunction

  function automatic longint smul_rnd(input longint a, input longint b, input int sh);
    logic [63:0] m;
    m = mul_rnd(a < 0 ? -a : a, b < 0 ? -b : b, sh);
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip41(input longint v);
    if (v > 64'sd1099511627775) return 64'sd1099511627775;
    if (v < -64'sd1099511627776) return -64'sd1099511627776;
    return v;
  endfunction

  // Sine and cosine in Q30 by CORDIC rotation; angles past a quarter turn
  // are folded by half a turn and negated afterward.
  function automatic void cordic_q30(input logic [31:0] ang, output longint s,
                                     output longint c);
    longint z, x, y, dx, dy;
    bit     flip;
    z = longint'($signed(ang));
    x = CORDIC_GAIN;
    y = 0;
    flip = 1'b0;
    if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30)) begin
      z = longint'($signed(ang + 32'h80000000));
      flip = 1'b1;
    end
    for (int i = 0; i < RUN_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ((i < 30) ? longint'(ARCTAN[i]) : 0);
      end else begin
        x = x + dx; y = y - dy; z = z + ((i < 30) ? longint'(ARCTAN[i]) : 0);
      end
    end
    x = (x + 512) >>> 10;
    y = (y + 512) >>> 10;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic coord_t to_ecef(input point_t p);
    coord_t       r;
    longint       sb, cb, sl, cl, h16, w2, p1, p3;
    logic [63:0]  ub, t, n, nz;
    logic [127:0] rad, cand, quo;
    cordic_q30(p.lat, sb, cb);
    cordic_q30(p.lon, sl, cl);
    h16 = longint'(p.hgt) * 16;
    ub = sb < 0 ? -sb : sb;
    t = mul_rnd({24'd0, ecc_r}, ub * ub, 60);
    w2 = longint'(Q40_ONE) - longint'(t);
    r = '0;
    if (w2 <= 1) begin
      r.degen = 1'b1;
      return r;
    end
    rad = '0;
    for (int b = 40; b >= 0; b--) begin
      cand = rad | (128'd1 << b);
      if (cand * cand <= (128'(w2) << 40)) rad = cand;
    end
    quo = ({92'd0, axis_r} << 44) / rad;
    n = quo[63:0];
    nz = mul_rnd(n, Q40_ONE - {24'd0, ecc_r}, 40);
    p1 = smul_rnd(longint'(n) + h16, cb, 30);
    p3 = longint'(nz) + h16;
    r.x = 41'(clip41(smul_rnd(p1, cl, 34)));
    r.y = 41'(clip41(smul_rnd(p1, sl, 34)));
    r.z = 41'(clip41(smul_rnd(p3, sb, 34)));
    return r;
  endfunction

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    point_t nxt;
    logic   hold;
    if (!rst_ni) begin
      start_i     <= 1'b0;
      latitude_i  <= '0;
      longitude_i <= '0;
      height_i    <= '0;
      burst_left  <= 1;
      gap_left    <= 0;
    end else begin
      hold = start_i && busy_o;
      if (start_i && !busy_o)
        coord_q.push_back(to_ecef({latitude_i, longitude_i, height_i}));
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start_i  <= 1'b0;
        end else if (point_q.size() > 0) begin
          nxt = point_q.pop_front();
          latitude_i  <= nxt.lat;
          longitude_i <= nxt.lon;
          height_i    <= nxt.hgt;
          start_i     <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(40, 1);
            gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    coord_t want;
    if (rst_ni && done_o) begin
      if (coord_q.size() == 0) begin
        $error("unexpected result x=%0d y=%0d z=%0d status=%0d",
               ecef_x_o, ecef_y_o, ecef_z_o, status_o);
        err_cnt++;
      end else begin
        want = coord_q.pop_front();
        if (ecef_x_o !== want.x) begin
          $error("ecef_x expected %0d actual %0d", want.x, ecef_x_o); err_cnt++;
        end
        if (ecef_y_o !== want.y) begin
          $error("ecef_y expected %0d actual %0d", want.y, ecef_y_o); err_cnt++;
        end
        if (ecef_z_o !== want.z) begin
          $error("ecef_z expected %0d actual %0d", want.z, ecef_z_o); err_cnt++;
        end
        if (status_o !== want.degen) begin
          $error("status expected %0d actual %0d", want.degen, status_o); err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [39:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == g2e_pkg::CFG_AXIS) axis_r = val[35:0];
    else ecc_r = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (point_q.size() > 0 || start_i || coord_q.size() > 0) @(posedge clk_i);
  endtask

  task automatic add_point(input longint lat, input longint lon, input longint hgt);
    point_t p;
    p.lat = 32'(lat);
    p.lon = 32'(lon);
    p.hgt = 37'(hgt);
    point_q.push_back(p);
  endtask

  function automatic longint rand_lat();
    int unsigned k;
    k = $urandom_range(9, 0);
    if (k == 0) return $urandom_range(1, 0) ? (64'sd1 <<< 30) : -(64'sd1 <<< 30);
    if (k == 1) return ($urandom_range(1, 0) ? 1 : -1) * ((64'sd1 <<< 30) -
                       $urandom_range(5000, 0));
    return longint'($urandom_range(32'h80000000, 0)) - (64'sd1 <<< 30);
  endfunction

  function automatic longint rand_hgt();
    int unsigned k;
    k = $urandom_range(7, 0);
    if (k == 0) return longint'($signed(37'({$urandom, $urandom})));
    if (k == 1) return ($urandom_range(1, 0) ? 64'sd68719476735 : -64'sd68719476736);
    return longint'($urandom_range(20000000, 0)) - 64'sd10000000;
  endfunction

  task automatic add_random(input int count);
    repeat (count) add_point(rand_lat(), longint'($signed($urandom)), rand_hgt());
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = g2e_pkg::CFG_AXIS;
    cfg_wdata_i = '0;
    axis_r      = AXIS_DEFAULT;
    ecc_r       = ECC_DEFAULT;
    err_cnt     = 0;
    cyc_cnt     = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Poles, equator, longitude wrap points and height extremes.
    add_point(0, 0, 0);
    add_point(64'sd1 <<< 30, 0, 0);
    add_point(-(64'sd1 <<< 30), 0, 0);
    add_point(0, 64'sd2147483647, 64'sd68719476735);
    add_point(0, -64'sd2147483648, -64'sd68719476736);
    add_point(64'sd536870912, 64'sd1073741825, 1000);
    add_point(-64'sd536870912, -64'sd1073741825, -1000);
    add_point(64'sd1073741823, 64'sd1073741824, 64'sd68719476735);
    add_point(-64'sd1073741823, -64'sd1073741824, -64'sd68719476736);
    add_point(12345, -1, -1);
    add_point(-1, 1, 1);
    add_point(64'sd715827882, 64'sd1431655765, 64'sd9000000);
    // Deep negative height drives the coordinates through zero.
    add_point(0, 64'sd300000000, -64'sd6531212288);
    add_random(190);
    drain();

    // Sphere with the largest axis: no flattening at all.
    write_reg(g2e_pkg::CFG_AXIS, 40'hFFFFFFFFF);
    write_reg(g2e_pkg::CFG_ECC, '0);
    add_point(64'sd1 <<< 30, 0, 64'sd68719476735);
    add_point(0, -64'sd2147483648, 64'sd68719476735);
    add_random(200);
    drain();

    // Largest eccentricity: poles give a degenerate root, near-poles saturate.
    write_reg(g2e_pkg::CFG_ECC, 40'hFFFFFFFFFF);
    add_point(64'sd1 <<< 30, 64'sd12345, 0);
    add_point(-(64'sd1 <<< 30), -64'sd12345, 0);
    add_point(64'sd1073700000, 64'sd100, 0);
    add_point(-64'sd1073700000, 64'sd2000000000, 0);
    add_random(200);
    drain();

    write_reg(g2e_pkg::CFG_AXIS, 36'd1);
    write_reg(g2e_pkg::CFG_ECC, 40'd1);
    add_random(120);
    drain();

    write_reg(g2e_pkg::CFG_AXIS, 36'({$urandom, $urandom}));
    write_reg(g2e_pkg::CFG_ECC, 40'({$urandom, $urandom}) >> $urandom_range(20, 0));
    add_random(150);
    drain();

    write_reg(g2e_pkg::CFG_AXIS, AXIS_DEFAULT);
    write_reg(g2e_pkg::CFG_ECC, ECC_DEFAULT);
    add_random(170);
    drain();

    repeat (LATENCY + 20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
